// ----- hw/rtl/p2dmx_pkg.sv -----
// Package for the pixel to DMX universe packer.
// Holds widths, the universe geometry, register indexes, the queue entry type and helpers.
// No dependencies; every other file of the block uses it.
package p2dmx_pkg;

    localparam int UNIVERSE_BYTES = 512;
    localparam int UNIV_W         = 16;
    localparam int SLOT_W         = 9;
    localparam int SUM_W          = SLOT_W + 1;
    localparam int PIX_CNT_W      = 8;
    localparam int BYTE_W         = 8;
    localparam int MAX_BYTES      = 8;
    localparam int BIDX_W         = $clog2(MAX_BYTES);
    localparam int BCNT_W         = BIDX_W + 1;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 1;

    // Whole pixels per universe for each pixel size.
    localparam int PPU_RGB8   = UNIVERSE_BYTES / 3;
    localparam int PPU_RGBA8  = UNIVERSE_BYTES / 4;
    localparam int PPU_RGB16  = UNIVERSE_BYTES / 6;
    localparam int PPU_RGBA16 = UNIVERSE_BYTES / 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIXTEEN_BIT  = 2'd0,
        CFG_ALPHA_OUT    = 2'd1,
        CFG_MSB_FIRST    = 2'd2,
        CFG_SOURCE_ALPHA = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic sixteen_bit;
        logic alpha_out;
        logic msb_first;
        logic source_alpha;
    } cfg_t;

    // One classified pixel, ready to be serialized.
    typedef struct packed {
        logic [MAX_BYTES-1:0][BYTE_W-1:0] data;
        logic [BCNT_W-1:0]                nbytes;
        logic [UNIV_W-1:0]                universe;
        logic [SLOT_W-1:0]                slot_base;
        logic                             univ_last;
        logic                             frame_last;
    } pixel_desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [BCNT_W-1:0] bytes_per_pixel(input logic sixteen,
                                                          input logic alpha);
        logic [BCNT_W-1:0] n;
        case ({sixteen, alpha})
            2'b00:   n = BCNT_W'(3);
            2'b01:   n = BCNT_W'(4);
            2'b10:   n = BCNT_W'(6);
            default: n = BCNT_W'(8);
        endcase
        return n;
    endfunction

    function automatic logic [PIX_CNT_W-1:0] pixels_per_universe(input logic sixteen,
                                                                 input logic alpha);
        logic [PIX_CNT_W-1:0] n;
        case ({sixteen, alpha})
            2'b00:   n = PIX_CNT_W'(PPU_RGB8);
            2'b01:   n = PIX_CNT_W'(PPU_RGBA8);
            2'b10:   n = PIX_CNT_W'(PPU_RGB16);
            default: n = PIX_CNT_W'(PPU_RGBA16);
        endcase
        return n;
    endfunction

    // Channel value times 257, kept to 16 bits.
    function automatic logic [2*BYTE_W-1:0] widen(input logic [BYTE_W-1:0] c);
        return {c, {BYTE_W{1'b0}}} + {{BYTE_W{1'b0}}, c};
    endfunction

endpackage

// ----- hw/rtl/p2dmx_pixel_if.sv -----
// Input channel of the packer: one RGBA pixel and its frame-end mark per transfer.
// Depends on p2dmx_pkg for the widths.
interface p2dmx_pixel_if;
    logic                          valid;
    logic                          ready;
    logic [p2dmx_pkg::BYTE_W-1:0]  red;
    logic [p2dmx_pkg::BYTE_W-1:0]  green;
    logic [p2dmx_pkg::BYTE_W-1:0]  blue;
    logic [p2dmx_pkg::BYTE_W-1:0]  alpha;
    logic                          frame_end;

    modport source (output valid, red, green, blue, alpha, frame_end, input ready);
    modport sink   (input valid, red, green, blue, alpha, frame_end, output ready);
endinterface

// ----- hw/rtl/p2dmx_byte_if.sv -----
// Output channel of the packer: one DMX channel byte with its position and marks per transfer.
// Depends on p2dmx_pkg for the widths.
interface p2dmx_byte_if;
    logic                          valid;
    logic                          ready;
    logic [p2dmx_pkg::BYTE_W-1:0]  out_byte;
    logic [p2dmx_pkg::UNIV_W-1:0]  universe;
    logic [p2dmx_pkg::SLOT_W-1:0]  slot;
    logic                          pixel_last;
    logic                          universe_last;
    logic                          frame_last;

    modport source (output valid, out_byte, universe, slot, pixel_last, universe_last,
                    frame_last, input ready);
    modport sink   (input valid, out_byte, universe, slot, pixel_last, universe_last,
                    frame_last, output ready);
endinterface

// ----- hw/rtl/p2dmx_front.sv -----
// Front end: accepts pixels, builds their channel bytes and places them in a universe.
// Owns the universe, pixel and slot counters. Depends on p2dmx_pkg and p2dmx_pixel_if.
module p2dmx_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  p2dmx_pkg::cfg_t        cfg,
    p2dmx_pixel_if.sink            pixel,
    input  p2dmx_pkg::queue_status_t qstat,
    output logic                   push,
    output p2dmx_pkg::pixel_desc_t push_desc
);

    logic [p2dmx_pkg::UNIV_W-1:0]    univ_reg, univ_next;
    logic [p2dmx_pkg::PIX_CNT_W-1:0] pix_reg, pix_next;
    logic [p2dmx_pkg::SLOT_W-1:0]    sbase_reg, sbase_next;

    logic [p2dmx_pkg::BCNT_W-1:0]    bpp;
    logic [p2dmx_pkg::PIX_CNT_W-1:0] ppu;
    logic                            advance;
    logic                            full;
    logic [p2dmx_pkg::UNIV_W-1:0]    univ_cur;
    logic [p2dmx_pkg::PIX_CNT_W-1:0] pix_cur;
    logic [p2dmx_pkg::SLOT_W-1:0]    sbase_cur;
    logic [p2dmx_pkg::BYTE_W-1:0]    ch [4];
    logic [2*p2dmx_pkg::BYTE_W-1:0]  wide;
    logic [p2dmx_pkg::MAX_BYTES-1:0][p2dmx_pkg::BYTE_W-1:0] bytes;

    assign pixel.ready = !qstat.full;
    assign push        = pixel.valid && pixel.ready;

    assign bpp = p2dmx_pkg::bytes_per_pixel(cfg.sixteen_bit, cfg.alpha_out);
    assign ppu = p2dmx_pkg::pixels_per_universe(cfg.sixteen_bit, cfg.alpha_out);

    // A configuration change can leave the open universe too small for this pixel;
    // it then moves on to a fresh universe without a closing mark.
    assign advance = (pix_reg >= ppu) ||
                     ({1'b0, sbase_reg} + p2dmx_pkg::SUM_W'(bpp) >
                      p2dmx_pkg::SUM_W'(p2dmx_pkg::UNIVERSE_BYTES));

    assign univ_cur  = advance ? univ_reg + 1'b1 : univ_reg;
    assign pix_cur   = advance ? '0 : pix_reg;
    assign sbase_cur = advance ? '0 : sbase_reg;

    assign full = ({1'b0, pix_cur} + 1'b1 >= {1'b0, ppu}) ||
                  ({1'b0, sbase_cur} + p2dmx_pkg::SUM_W'({bpp, 1'b0}) >
                   p2dmx_pkg::SUM_W'(p2dmx_pkg::UNIVERSE_BYTES));

    always_comb
    begin
        ch[0] = pixel.red;
        ch[1] = pixel.green;
        ch[2] = pixel.blue;
        ch[3] = cfg.source_alpha ? pixel.alpha : {p2dmx_pkg::BYTE_W{1'b1}};
        bytes = '0;
        wide  = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (cfg.sixteen_bit)
            begin
                wide = p2dmx_pkg::widen(ch[i]);
                bytes[2*i]   = cfg.msb_first ? wide[15:8] : wide[7:0];
                bytes[2*i+1] = cfg.msb_first ? wide[7:0]  : wide[15:8];
            end
            else
            begin
                bytes[i] = ch[i];
            end
        end
    end

    always_comb
    begin
        push_desc.data       = bytes;
        push_desc.nbytes     = bpp;
        push_desc.universe   = univ_cur;
        push_desc.slot_base  = sbase_cur;
        push_desc.univ_last  = full || pixel.frame_end;
        push_desc.frame_last = pixel.frame_end;
    end

    always_comb
    begin
        univ_next  = univ_reg;
        pix_next   = pix_reg;
        sbase_next = sbase_reg;
        if (push)
        begin
            if (pixel.frame_end)
            begin
                univ_next  = '0;
                pix_next   = '0;
                sbase_next = '0;
            end
            else if (full)
            begin
                univ_next  = univ_cur + 1'b1;
                pix_next   = '0;
                sbase_next = '0;
            end
            else
            begin
                univ_next  = univ_cur;
                pix_next   = pix_cur + 1'b1;
                sbase_next = sbase_cur + p2dmx_pkg::SLOT_W'(bpp);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            univ_reg  <= '0;
            pix_reg   <= '0;
            sbase_reg <= '0;
        end
        else
        begin
            univ_reg  <= univ_next;
            pix_reg   <= pix_next;
            sbase_reg <= sbase_next;
        end
    end

endmodule

// ----- hw/rtl/p2dmx_queue.sv -----
// Short queue of classified pixels between the front end and the serializer.
// Depends on p2dmx_pkg for the entry type and depth.
module p2dmx_queue
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  p2dmx_pkg::pixel_desc_t    push_desc,
    input  logic                      pop,
    output p2dmx_pkg::pixel_desc_t    head,
    output p2dmx_pkg::queue_status_t  qstat
);

    p2dmx_pkg::pixel_desc_t           mem_reg [p2dmx_pkg::QUEUE_DEPTH];
    logic [p2dmx_pkg::QPTR_W-1:0]     wr_reg, wr_next;
    logic [p2dmx_pkg::QPTR_W-1:0]     rd_reg, rd_next;
    logic [p2dmx_pkg::QCNT_W-1:0]     count_reg, count_next;

    assign head        = mem_reg[rd_reg];
    assign qstat.full  = (count_reg == p2dmx_pkg::QCNT_W'(p2dmx_pkg::QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_next = (wr_reg == p2dmx_pkg::QPTR_W'(p2dmx_pkg::QUEUE_DEPTH - 1)) ?
                      '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == p2dmx_pkg::QPTR_W'(p2dmx_pkg::QUEUE_DEPTH - 1)) ?
                      '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- hw/rtl/p2dmx_back.sv -----
// Serializer: walks the bytes of the pixel at the queue head into a registered output stage.
// Depends on p2dmx_pkg and p2dmx_byte_if.
module p2dmx_back
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  p2dmx_pkg::pixel_desc_t    head,
    input  p2dmx_pkg::queue_status_t  qstat,
    output logic                      pop,
    p2dmx_byte_if.source              dmx
);

    logic [p2dmx_pkg::BIDX_W-1:0]  idx_reg, idx_next;
    logic                          valid_reg, valid_next;
    logic [p2dmx_pkg::BYTE_W-1:0]  byte_reg;
    logic [p2dmx_pkg::UNIV_W-1:0]  univ_reg;
    logic [p2dmx_pkg::SLOT_W-1:0]  slot_reg;
    logic                          plast_reg;
    logic                          ulast_reg;
    logic                          flast_reg;

    logic                          load;
    logic                          last_byte;

    // With a pixel queued, the output stage takes a new byte when empty or its byte is taken.
    assign load      = !qstat.empty && (!valid_reg || dmx.ready);
    assign last_byte = ({1'b0, idx_reg} + 1'b1 == head.nbytes);
    assign pop       = load && last_byte;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = last_byte ? '0 : idx_reg + 1'b1;
        end
        else if (dmx.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg  <= head.data[idx_reg];
            univ_reg  <= head.universe;
            slot_reg  <= head.slot_base + p2dmx_pkg::SLOT_W'(idx_reg);
            plast_reg <= last_byte;
            ulast_reg <= last_byte && head.univ_last;
            flast_reg <= last_byte && head.frame_last;
        end
    end

    assign dmx.valid         = valid_reg;
    assign dmx.out_byte      = byte_reg;
    assign dmx.universe      = univ_reg;
    assign dmx.slot          = slot_reg;
    assign dmx.pixel_last    = plast_reg;
    assign dmx.universe_last = ulast_reg;
    assign dmx.frame_last    = flast_reg;

endmodule

// ----- hw/rtl/pixel_to_dmx_universe_packer.sv -----
// Pixel to DMX universe packer, top level. A transferred pixel is registered in the queue,
// then its bytes go through the serializer's registered output stage. Throughput: one byte
// per cycle while dmx.ready is high and the queue holds a pixel; a pixel is 3, 4, 6 or 8
// bytes (RGB/RGBA, 8/16 bit). The rate is set by the single-byte output register of the
// serializer. A two-entry pixel queue lets the input take pixels while bytes are still
// going out. Reset: counters zero, queue and output empty, registers to their defaults.
module pixel_to_dmx_universe_packer
(
    input  logic                               clk,
    input  logic                               rst_n,
    p2dmx_pixel_if.sink                        pixel,
    p2dmx_byte_if.source                       dmx,
    input  logic                               cfg_we,
    input  logic [p2dmx_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [p2dmx_pkg::CFG_DATA_W-1:0]   cfg_data
);

    p2dmx_pkg::cfg_t           cfg_reg;
    p2dmx_pkg::pixel_desc_t    push_desc;
    p2dmx_pkg::pixel_desc_t    head;
    p2dmx_pkg::queue_status_t  qstat;
    logic                      push;
    logic                      pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sixteen_bit  <= 1'b0;
            cfg_reg.alpha_out    <= 1'b0;
            cfg_reg.msb_first    <= 1'b1;
            cfg_reg.source_alpha <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (p2dmx_pkg::cfg_idx_t'(cfg_index))
                p2dmx_pkg::CFG_SIXTEEN_BIT:  cfg_reg.sixteen_bit  <= cfg_data[0];
                p2dmx_pkg::CFG_ALPHA_OUT:    cfg_reg.alpha_out    <= cfg_data[0];
                p2dmx_pkg::CFG_MSB_FIRST:    cfg_reg.msb_first    <= cfg_data[0];
                p2dmx_pkg::CFG_SOURCE_ALPHA: cfg_reg.source_alpha <= cfg_data[0];
                default:                     cfg_reg              <= cfg_reg;
            endcase
        end
    end

    p2dmx_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pixel     (pixel),
        .qstat     (qstat),
        .push      (push),
        .push_desc (push_desc)
    );

    p2dmx_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    p2dmx_back u_back
    (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .qstat (qstat),
        .pop   (pop),
        .dmx   (dmx)
    );

endmodule
